// File: rtl/lmrs_pkg.sv
// Shared types, sizes and tables for the LED matrix row-scan scroller.
// Used by lmrs_ctrl, lmrs_datapath and led_matrix_row_scan_scroller_unit.
package lmrs_pkg;

    localparam int MAX_GLYPHS     = 128;
    localparam int GLYPHS_PER_ROW = 4;
    localparam int GLYPH_BYTES    = 32;
    localparam int SCAN_ROWS      = 16;

    localparam int GLYPH_W     = $clog2(MAX_GLYPHS);
    localparam int BYTE_W      = $clog2(GLYPH_BYTES);
    localparam int ADDR_W      = GLYPH_W + BYTE_W;
    localparam int STORE_DEPTH = MAX_GLYPHS * GLYPH_BYTES;

    localparam int ROW_BYTES = 2 * GLYPHS_PER_ROW;
    localparam int IDX_W     = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int RCNT_W    = $clog2(ROW_BYTES + 1);

    localparam int ROW_W   = 4;
    localparam int OFF_W   = 7;
    localparam int SLOT_W  = 7;
    localparam int BSLOT_W = 5;
    localparam int PIX_W   = 8;
    localparam int CNT_W   = 8;
    localparam int LEN_W   = 9;
    localparam int CMP_W   = LEN_W + 1;
    localparam int DATA_W  = 64;

    localparam int CMD_W       = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCROLL_MODE = 1'd0,
        REG_CHAR_COUNT  = 1'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic             load;
        logic             set_pending;
        logic             restart;
        logic             tick_start;
        logic             clr_step;
        logic             rd_issue;
        logic [IDX_W-1:0] rd_idx;
        logic             shift;
        logic             load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } dp_stat_t;

    // Message length rounded up to a whole number of windows, per char_count value.
    typedef logic [LEN_W-1:0] len_table_t [2**CNT_W];

    function automatic len_table_t build_len_table();
        len_table_t tbl;
        int         n;
        int         r;
        for (int i = 0; i < 2**CNT_W; i++)
        begin
            n = i;
            r = i % GLYPHS_PER_ROW;
            if (r != 0)
            begin
                n = n + GLYPHS_PER_ROW - r;
            end
            tbl[i] = LEN_W'(n);
        end
        return tbl;
    endfunction

    localparam len_table_t LEN_TABLE = build_len_table();

endpackage

// File: rtl/lmrs_ctrl.sv
// Sequencer for the row-scan scroller: clearing pass, command decode,
// row read sequence and output hand-off. Depends on lmrs_pkg.
module lmrs_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic [lmrs_pkg::CMD_W-1:0] s_cmd,
    output logic                      s_tready,
    input  lmrs_pkg::dp_stat_t         stat,
    output lmrs_pkg::dp_cmd_t          cmd
);

    lmrs_pkg::state_t                state_reg;
    lmrs_pkg::state_t                state_next;
    logic [lmrs_pkg::RCNT_W-1:0]     cnt_reg;
    logic [lmrs_pkg::RCNT_W-1:0]     cnt_next;
    lmrs_pkg::cmd_code_t             code;

    assign code = lmrs_pkg::cmd_code_t'(s_cmd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmrs_pkg::ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            lmrs_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = lmrs_pkg::ST_IDLE;
                end
            end
            lmrs_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (code)
                        lmrs_pkg::CMD_LOAD:    cmd.load = 1'b1;
                        lmrs_pkg::CMD_ADVANCE: cmd.set_pending = 1'b1;
                        lmrs_pkg::CMD_RESTART: cmd.restart = 1'b1;
                        lmrs_pkg::CMD_TICK:
                        begin
                            cmd.tick_start = 1'b1;
                            cnt_next       = '0;
                            state_next     = lmrs_pkg::ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            lmrs_pkg::ST_READ:
            begin
                // issue byte cnt, shift in byte cnt-1 from the registered read
                cmd.rd_idx = cnt_reg[lmrs_pkg::IDX_W-1:0];
                cmd.shift  = (cnt_reg != '0);
                if (cnt_reg == lmrs_pkg::RCNT_W'(lmrs_pkg::ROW_BYTES))
                begin
                    state_next = lmrs_pkg::ST_WAIT;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
            end
            lmrs_pkg::ST_WAIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = lmrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lmrs_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/lmrs_datapath.sv
// Datapath of the row-scan scroller: glyph store, configuration, scan and
// window registers, row shift register and output register. Depends on lmrs_pkg.
module lmrs_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lmrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmrs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [lmrs_pkg::SLOT_W-1:0]     glyph_slot,
    input  logic [lmrs_pkg::BSLOT_W-1:0]    byte_slot,
    input  logic [lmrs_pkg::PIX_W-1:0]      glyph_byte,
    input  lmrs_pkg::dp_cmd_t               cmd,
    output lmrs_pkg::dp_stat_t              stat,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [lmrs_pkg::DATA_W-1:0]     row_data,
    output logic [lmrs_pkg::ROW_W-1:0]      row_select,
    output logic [lmrs_pkg::OFF_W-1:0]      window_start
);

    logic [lmrs_pkg::PIX_W-1:0] mem [lmrs_pkg::STORE_DEPTH];

    logic                          scroll_mode_reg;
    logic [lmrs_pkg::CNT_W-1:0]    char_count_reg;
    logic [lmrs_pkg::ROW_W-1:0]    scan_row_reg;
    logic [lmrs_pkg::OFF_W-1:0]    window_offset_reg;
    logic [lmrs_pkg::OFF_W-1:0]    window_offset_next;
    logic                          pending_reg;
    logic [lmrs_pkg::ADDR_W-1:0]   clr_addr_reg;
    logic [lmrs_pkg::DATA_W-1:0]   shift_reg;
    logic                          blank_reg;
    logic [lmrs_pkg::PIX_W-1:0]    rd_data_reg;
    logic                          out_valid_reg;
    logic [lmrs_pkg::DATA_W-1:0]   out_data_reg;
    logic [lmrs_pkg::ROW_W-1:0]    out_select_reg;
    logic [lmrs_pkg::OFF_W-1:0]    out_start_reg;

    logic [lmrs_pkg::LEN_W-1:0]    len;
    logic [lmrs_pkg::CMP_W-1:0]    len_ext;
    logic [lmrs_pkg::CMP_W-1:0]    off_ext;
    logic [lmrs_pkg::CMP_W-1:0]    pos_ext;
    logic [lmrs_pkg::CMP_W-1:0]    off_plus1;
    logic [lmrs_pkg::CMP_W-1:0]    off_plus_g;
    logic                          blank_next;
    logic [31:0]                   slot32;
    logic [lmrs_pkg::ADDR_W-1:0]   load_addr;
    logic [lmrs_pkg::ADDR_W-1:0]   rd_addr;
    logic [lmrs_pkg::ADDR_W-1:0]   wr_addr;
    logic [lmrs_pkg::PIX_W-1:0]    wr_data;
    logic                          wr_en;
    logic [lmrs_pkg::PIX_W-1:0]    next_byte;

    assign len     = lmrs_pkg::LEN_TABLE[char_count_reg];
    assign len_ext = lmrs_pkg::CMP_W'(len);
    assign off_ext = lmrs_pkg::CMP_W'(window_offset_reg);
    assign pos_ext = off_ext + lmrs_pkg::CMP_W'(cmd.rd_idx >> 1);

    // past the message end, page mode shows blank glyphs
    assign blank_next = !scroll_mode_reg && (pos_ext >= len_ext);

    assign rd_addr = {pos_ext[lmrs_pkg::GLYPH_W-1:0], scan_row_reg, cmd.rd_idx[0]};

    assign slot32    = 32'(glyph_slot);
    assign load_addr = {slot32[lmrs_pkg::GLYPH_W-1:0], byte_slot};

    assign wr_en   = cmd.load || cmd.clr_step;
    assign wr_addr = cmd.clr_step ? clr_addr_reg : load_addr;
    assign wr_data = cmd.clr_step ? '0 : glyph_byte;

    assign next_byte = blank_reg ? {lmrs_pkg::PIX_W{1'b1}} : ~rd_data_reg;

    // window step taken at the frame wrap
    assign off_plus1  = off_ext + lmrs_pkg::CMP_W'(1);
    assign off_plus_g = off_ext + lmrs_pkg::CMP_W'(lmrs_pkg::GLYPHS_PER_ROW);

    always_comb
    begin
        logic [lmrs_pkg::CMP_W-1:0] wide;
        if (scroll_mode_reg)
        begin
            wide = off_plus1;
            if ((off_plus1 + lmrs_pkg::CMP_W'(lmrs_pkg::GLYPHS_PER_ROW)) > len_ext)
            begin
                wide = '0;
            end
        end
        else
        begin
            wide = '0;
            if (off_plus_g < len_ext)
            begin
                wide = off_plus_g;
            end
        end
        window_offset_next = wide[lmrs_pkg::OFF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            blank_reg <= blank_next;
        end
        if (cmd.tick_start)
        begin
            shift_reg <= '0;
        end
        else if (cmd.shift)
        begin
            shift_reg <= {shift_reg[lmrs_pkg::DATA_W-lmrs_pkg::PIX_W-1:0], next_byte};
        end
        if (cmd.load_out)
        begin
            out_data_reg   <= shift_reg;
            out_select_reg <= lmrs_pkg::ROW_W'(lmrs_pkg::SCAN_ROWS - 1) - scan_row_reg;
            out_start_reg  <= window_offset_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_mode_reg   <= 1'b1;
            char_count_reg    <= '0;
            scan_row_reg      <= '0;
            window_offset_reg <= '0;
            pending_reg       <= 1'b0;
            clr_addr_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (lmrs_pkg::reg_index_t'(cfg_index))
                    lmrs_pkg::REG_SCROLL_MODE: scroll_mode_reg <= cfg_data[0];
                    lmrs_pkg::REG_CHAR_COUNT:  char_count_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.set_pending)
            begin
                pending_reg <= 1'b1;
            end
            if (cmd.restart)
            begin
                scan_row_reg      <= '0;
                window_offset_reg <= '0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
                scan_row_reg  <= scan_row_reg + 1'b1;
                if (scan_row_reg == lmrs_pkg::ROW_W'(lmrs_pkg::SCAN_ROWS - 1) && pending_reg)
                begin
                    pending_reg       <= 1'b0;
                    window_offset_reg <= window_offset_next;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clr_last = (clr_addr_reg == {lmrs_pkg::ADDR_W{1'b1}});
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid     = out_valid_reg;
    assign row_data     = out_data_reg;
    assign row_select   = out_select_reg;
    assign window_start = out_start_reg;

endmodule

// File: rtl/led_matrix_row_scan_scroller_unit.sv
// Row-scan scroller top: load, advance and restart requests complete in IDLE on acceptance.
// A row tick reads 2*GLYPHS_PER_ROW glyph bytes from the glyph store, one a cycle,
// in the READ state, then waits in WAIT until the output register is free; no new
// request is taken until the row result has been loaded into the output register.
// Reset (rst_n, async low) clears control state, then a clearing pass blanks all
// MAX_GLYPHS*32 glyph store bytes (4096) with s_tready low; cfg writes still land.
module led_matrix_row_scan_scroller_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [6:0] glyph_slot, [11:7] byte_slot, [19:12] glyph_byte, [23:20] zero
    input  logic [lmrs_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [1:0] cmd
    input  logic [lmrs_pkg::CMD_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [63:0] row_data, [67:64] row_select, [74:68] window_start, [79:75] zero
    output logic [lmrs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_we,
    input  logic [lmrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lmrs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int OUT_USED = lmrs_pkg::DATA_W + lmrs_pkg::ROW_W + lmrs_pkg::OFF_W;

    lmrs_pkg::dp_cmd_t              cmd;
    lmrs_pkg::dp_stat_t             stat;
    logic [lmrs_pkg::DATA_W-1:0]    row_data;
    logic [lmrs_pkg::ROW_W-1:0]     row_select;
    logic [lmrs_pkg::OFF_W-1:0]     window_start;

    lmrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lmrs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .glyph_slot   (s_tdata[6:0]),
        .byte_slot    (s_tdata[11:7]),
        .glyph_byte   (s_tdata[19:12]),
        .cmd          (cmd),
        .stat         (stat),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .row_data     (row_data),
        .row_select   (row_select),
        .window_start (window_start)
    );

    assign m_tdata = {{(lmrs_pkg::OUT_TDATA_W - OUT_USED){1'b0}},
                      window_start, row_select, row_data};

    // never overwrite a result that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while held");

    // no request taken while a row read or the clearing pass is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!cmd.rd_issue && !cmd.shift && !cmd.clr_step))
        else $error("request accepted during row read or clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_tvalid)
        else $error("result lost after load");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !cmd.load_out) |=> !m_tvalid)
        else $error("result repeated after it was taken");

endmodule

// File: test/led_matrix_row_scan_scroller_unit_tb.sv
// Self-checking testbench for led_matrix_row_scan_scroller_unit: glyph loads, row ticks,
// window moves in scroll and page mode, checked against an in-bench row predictor.
// Depends on lmrs_pkg and the RTL of led_matrix_row_scan_scroller_unit only.
module led_matrix_row_scan_scroller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int FRAME_ROWS     = 16;

    typedef struct packed {
        logic [6:0]  window_start;
        logic [3:0]  row_select;
        logic [63:0] row_data;
    } row_frame_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [lmrs_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [lmrs_pkg::CMD_W-1:0]       s_tuser   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [lmrs_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             cfg_we    = 1'b0;
    logic [lmrs_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [lmrs_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // predicted block state
    logic [7:0] glyph_mem [lmrs_pkg::STORE_DEPTH];
    logic [3:0] pred_row;
    logic [6:0] pred_offset;
    logic       pred_pending;
    logic       pred_scroll;
    logic [7:0] pred_char_count;

    row_frame_t pending_rows [$];

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_asked   = 0;
    int hold_given   = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;

    led_matrix_row_scan_scroller_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Build one scanned row from the predicted state, then step the row and window.
    function automatic row_frame_t scan_row_tick();
        row_frame_t frame;
        int         msg_len;
        int         pos;
        int         step;
        logic       blank;
        logic [7:0] pix;
        msg_len = pred_char_count;
        if (msg_len % lmrs_pkg::GLYPHS_PER_ROW != 0)
        begin
            msg_len = msg_len + lmrs_pkg::GLYPHS_PER_ROW
                      - msg_len % lmrs_pkg::GLYPHS_PER_ROW;
        end
        frame.row_data = '0;
        for (int k = 0; k < lmrs_pkg::GLYPHS_PER_ROW; k++)
        begin
            pos   = pred_offset + k;
            blank = !pred_scroll && (pos >= msg_len);
            for (int h = 0; h < 2; h++)
            begin
                pix = blank ? 8'h00
                            : glyph_mem[(pos % lmrs_pkg::MAX_GLYPHS) * lmrs_pkg::GLYPH_BYTES
                                        + pred_row * 2 + h];
                frame.row_data = {frame.row_data[55:0], ~pix};
            end
        end
        frame.row_select   = 4'(lmrs_pkg::SCAN_ROWS - 1 - pred_row);
        frame.window_start = pred_offset;
        if (pred_row == 4'(lmrs_pkg::SCAN_ROWS - 1))
        begin
            pred_row = '0;
            if (pred_pending)
            begin
                pred_pending = 1'b0;
                step = pred_offset;
                if (pred_scroll)
                begin
                    step = step + 1;
                    if (step + lmrs_pkg::GLYPHS_PER_ROW > msg_len)
                    begin
                        step = 0;
                    end
                end
                else if (step + lmrs_pkg::GLYPHS_PER_ROW < msg_len)
                begin
                    step = step + lmrs_pkg::GLYPHS_PER_ROW;
                end
                else
                begin
                    step = 0;
                end
                pred_offset = 7'(step);
            end
        end
        else
        begin
            pred_row = pred_row + 4'd1;
        end
        return frame;
    endfunction

    // result side: check, then pick m_tready for the next cycle
    always @(posedge clk)
    begin
        row_frame_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected row result: expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want = pending_rows.pop_front();
                if (m_tdata[63:0] !== want.row_data)
                begin
                    mismatches++;
                    $display("%0t row_data: expected %h, actual %h",
                             $time, want.row_data, m_tdata[63:0]);
                end
                if (m_tdata[67:64] !== want.row_select)
                begin
                    mismatches++;
                    $display("%0t row_select: expected %0d, actual %0d",
                             $time, want.row_select, m_tdata[67:64]);
                end
                if (m_tdata[74:68] !== want.window_start)
                begin
                    mismatches++;
                    $display("%0t window_start: expected %0d, actual %0d",
                             $time, want.window_start, m_tdata[74:68]);
                end
            end
        end
        if (hold_asked != hold_given)
        begin
            hold_given = hold_asked;
            hold_left  = RX_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t no request or result moved for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(input lmrs_pkg::cmd_code_t op, input logic [6:0] slot,
                             input logic [4:0] bsel, input logic [7:0] pix);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, pix, bsel, slot};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        case (op)
            lmrs_pkg::CMD_LOAD:    glyph_mem[{slot, bsel}] = pix;
            lmrs_pkg::CMD_TICK:    pending_rows.push_back(scan_row_tick());
            lmrs_pkg::CMD_ADVANCE: pred_pending = 1'b1;
            lmrs_pkg::CMD_RESTART:
            begin
                pred_row    = '0;
                pred_offset = '0;
            end
        endcase
    endtask

    // non-load request with junk in the unused fields
    task automatic send_cmd(input lmrs_pkg::cmd_code_t op);
        send_item(op, 7'($urandom), 5'($urandom), 8'($urandom));
    endtask

    task automatic send_side_request(input int restart_pct);
        int         pick;
        logic [6:0] slot;
        logic [7:0] pix;
        pick = $urandom_range(99);
        if (pick < restart_pct)
        begin
            send_cmd(lmrs_pkg::CMD_RESTART);
        end
        else if (pick < restart_pct + 15)
        begin
            send_cmd(lmrs_pkg::CMD_ADVANCE);
        end
        else
        begin
            // favor glyphs inside the current window so the loads show up
            if ($urandom_range(99) < 60)
            begin
                slot = 7'(pred_offset + $urandom_range(lmrs_pkg::GLYPHS_PER_ROW - 1));
            end
            else
            begin
                slot = 7'($urandom);
            end
            case ($urandom_range(9))
                0:       pix = 8'h00;
                1:       pix = 8'hFF;
                default: pix = 8'($urandom);
            endcase
            send_item(lmrs_pkg::CMD_LOAD, slot, 5'($urandom), pix);
        end
    endtask

    // Sixteen row ticks per frame, side requests mixed in, an advance in some frames.
    task automatic play_frames(input int frames, input int adv_pct,
                               input int side_pct, input int restart_pct);
        int adv_row;
        for (int f = 0; f < frames; f++)
        begin
            adv_row = ($urandom_range(99) < adv_pct) ? int'($urandom_range(FRAME_ROWS - 1)) : -1;
            for (int r = 0; r < FRAME_ROWS; r++)
            begin
                while ($urandom_range(99) < side_pct)
                begin
                    send_side_request(restart_pct);
                end
                if (r == adv_row)
                begin
                    send_cmd(lmrs_pkg::CMD_ADVANCE);
                end
                send_cmd(lmrs_pkg::CMD_TICK);
            end
        end
    endtask

    // Drop valid, wait for every row result, then let the block go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input lmrs_pkg::reg_index_t idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            lmrs_pkg::REG_SCROLL_MODE: pred_scroll     = value[0];
            lmrs_pkg::REG_CHAR_COUNT:  pred_char_count = value;
        endcase
        @(posedge clk);
    endtask

    // Store is blank after reset and the registers sit at their reset values.
    task automatic test_blank_store();
        send_cmd(lmrs_pkg::CMD_TICK);
    endtask

    task automatic test_directed();
        settle();
        write_reg(lmrs_pkg::REG_SCROLL_MODE, 8'd1);
        write_reg(lmrs_pkg::REG_CHAR_COUNT, 8'd8);
        send_item(lmrs_pkg::CMD_LOAD, 7'd0, 5'd0, 8'h80);
        send_item(lmrs_pkg::CMD_LOAD, 7'd0, 5'd1, 8'h01);
        send_item(lmrs_pkg::CMD_LOAD, 7'd3, 5'd31, 8'hFF);
        send_item(lmrs_pkg::CMD_LOAD, 7'd127, 5'd30, 8'h00);
        send_item(lmrs_pkg::CMD_LOAD, 7'd4, 5'd0, 8'h5A);
        send_cmd(lmrs_pkg::CMD_RESTART);
        // two advances in one frame move the window once
        for (int r = 0; r < FRAME_ROWS; r++)
        begin
            if (r == 3 || r == 9)
            begin
                send_cmd(lmrs_pkg::CMD_ADVANCE);
            end
            send_cmd(lmrs_pkg::CMD_TICK);
        end
        send_cmd(lmrs_pkg::CMD_TICK);
    endtask

    task automatic test_page_blanking();
        settle();
        write_reg(lmrs_pkg::REG_SCROLL_MODE, 8'd0);
        write_reg(lmrs_pkg::REG_CHAR_COUNT, 8'd5);
        send_cmd(lmrs_pkg::CMD_RESTART);
        // hold results off while ticks keep coming so the input stalls
        hold_asked++;
        for (int i = 0; i < 12; i++)
        begin
            send_cmd(lmrs_pkg::CMD_TICK);
        end
        settle();
        play_frames(2, 100, 20, 0);
        settle();
        write_reg(lmrs_pkg::REG_CHAR_COUNT, 8'd1);
        play_frames(2, 100, 20, 0);
        settle();
        write_reg(lmrs_pkg::REG_CHAR_COUNT, 8'd12);
        play_frames(2, 100, 25, 4);
    endtask

    // Long message: page up to offset 124, then scroll past the end of the
    // store until the 7-bit offset wraps.
    task automatic test_long_message();
        settle();
        write_reg(lmrs_pkg::REG_SCROLL_MODE, 8'd0);
        write_reg(lmrs_pkg::REG_CHAR_COUNT, 8'd255);
        send_cmd(lmrs_pkg::CMD_RESTART);
        play_frames(31, 100, 15, 0);
        settle();
        write_reg(lmrs_pkg::REG_SCROLL_MODE, 8'd1);
        play_frames(5, 100, 15, 0);
    endtask

    task automatic test_random_mix();
        logic [7:0] count;
        for (int i = 0; i < 10; i++)
        begin
            case (i)
                0, 1:    count = 8'd0;
                2, 3:    count = 8'd128;
                default: count = 8'($urandom_range(128));
            endcase
            settle();
            write_reg(lmrs_pkg::REG_SCROLL_MODE, 8'(i % 2));
            write_reg(lmrs_pkg::REG_CHAR_COUNT, count);
            play_frames(2, 80, 25, 3);
        end
    endtask

    initial
    begin
        for (int i = 0; i < lmrs_pkg::STORE_DEPTH; i++)
        begin
            glyph_mem[i] = 8'h00;
        end
        pred_row        = '0;
        pred_offset     = '0;
        pred_pending    = 1'b0;
        pred_scroll     = 1'b1;
        pred_char_count = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 12;
        rx_idle_pct = 80;
        test_blank_store();
        test_directed();
        test_page_blanking();

        tx_idle_pct = 80;
        rx_idle_pct = 12;
        test_long_message();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_mix();

        settle();
        if (mismatches == 0 && pending_rows.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
